FILE: hw/rtl/esort_pkg.sv
// Shared types and constants for the exchange sort engine.
package esort_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One queued input transaction, already classified by the front end.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
    logic                     keep;   // Entry fits in the store.
  } entry_t;

endpackage

FILE: hw/rtl/esort_front.sv
// Front end: accepts input transactions, classifies them and queues them.
module esort_front #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [esort_pkg::DATA_W-1:0]   value_i,
  input  logic                                  last_item_i,
  output logic                                  q_valid_o,
  output esort_pkg::entry_t                     q_entry_o,
  input  logic                                  q_pop_i
);

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  esort_pkg::entry_t queue_q [esort_pkg::QUEUE_DEPTH];

  logic [esort_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [esort_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [esort_pkg::QPTR_W:0]   level_q, level_d;
  logic [CNT_W-1:0]             set_cnt_q, set_cnt_d;
  logic                         push, pop, keep;

  assign in_ready_o = (level_q != (esort_pkg::QPTR_W+1)'(esort_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (level_q != '0);
  assign q_entry_o  = queue_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && q_valid_o;
  assign keep = (set_cnt_q < CNT_W'(MAX_ELEMENTS));

  always_comb begin
    wr_ptr_d  = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d  = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    level_d   = level_q;
    if (push && !pop) begin
      level_d = level_q + 1'b1;
    end else if (pop && !push) begin
      level_d = level_q - 1'b1;
    end
    // Count the elements of the open set so that overflow items are tagged.
    set_cnt_d = set_cnt_q;
    if (push) begin
      if (last_item_i) begin
        set_cnt_d = '0;
      end else if (keep) begin
        set_cnt_d = set_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      level_q   <= '0;
      set_cnt_q <= '0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      level_q   <= level_d;
      set_cnt_q <= set_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= '{value: value_i, last_item: last_item_i, keep: keep};
    end
  end

endmodule

FILE: hw/rtl/esort_back.sv
// Back end: loads the store, runs the exchange sort and emits the results.
module esort_back #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  esort_pkg::entry_t                     q_entry_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [esort_pkg::DATA_W-1:0]   sorted_value_o,
  output logic                                  last_result_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_PSTART = 3'd1;
  localparam logic [2:0] S_PLOAD  = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_PWB    = 3'd4;
  localparam logic [2:0] S_EREAD  = 3'd5;
  localparam logic [2:0] S_EOUT   = 3'd6;

  logic signed [esort_pkg::DATA_W-1:0] mem [MAX_ELEMENTS];

  logic [2:0]                          state_q, state_d;
  logic [CNT_W-1:0]                    fill_q, fill_d;
  logic [CNT_W-1:0]                    num_q, num_d;
  logic [CNT_W-1:0]                    p_q, p_d;
  logic [CNT_W-1:0]                    q_q, q_d;
  logic [CNT_W-1:0]                    k_q, k_d;
  logic signed [esort_pkg::DATA_W-1:0] cur_q, cur_d;
  logic signed [esort_pkg::DATA_W-1:0] rdata_q;
  logic [IDX_W-1:0]                    rd_addr, wr_addr;
  logic signed [esort_pkg::DATA_W-1:0] wr_data;
  logic                                wr_en;
  logic [CNT_W-1:0]                    p_inc, q_inc, k_inc;
  logic                                out_valid_q, out_valid_d;
  logic signed [esort_pkg::DATA_W-1:0] out_value_q, out_value_d;
  logic                                out_last_q, out_last_d;
  logic                                out_free;

  assign p_inc    = p_q + 1'b1;
  assign q_inc    = q_q + 1'b1;
  assign k_inc    = k_q + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_result_o  = out_last_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    num_d       = num_q;
    p_d         = p_q;
    q_d         = q_q;
    k_d         = k_q;
    cur_d       = cur_q;
    rd_addr     = '0;
    wr_addr     = '0;
    wr_data     = cur_q;
    wr_en       = 1'b0;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_LOAD: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_entry_i.keep) begin
            wr_en   = 1'b1;
            wr_addr = fill_q[IDX_W-1:0];
            wr_data = q_entry_i.value;
            fill_d  = fill_q + 1'b1;
          end
          if (q_entry_i.last_item) begin
            num_d   = fill_q + CNT_W'(q_entry_i.keep);
            p_d     = '0;
            state_d = S_PSTART;
          end
        end
      end
      S_PSTART: begin
        if (p_inc >= num_q) begin
          k_d     = '0;
          state_d = S_EREAD;
        end else begin
          rd_addr = p_q[IDX_W-1:0];
          q_d     = p_inc;
          state_d = S_PLOAD;
        end
      end
      S_PLOAD: begin
        cur_d   = rdata_q;
        rd_addr = q_q[IDX_W-1:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        // A smaller later entry trades places with the held entry.
        if (rdata_q < cur_q) begin
          wr_en   = 1'b1;
          wr_addr = q_q[IDX_W-1:0];
          wr_data = cur_q;
          cur_d   = rdata_q;
        end
        if (q_inc < num_q) begin
          q_d     = q_inc;
          rd_addr = q_inc[IDX_W-1:0];
        end else begin
          state_d = S_PWB;
        end
      end
      S_PWB: begin
        wr_en   = 1'b1;
        wr_addr = p_q[IDX_W-1:0];
        wr_data = cur_q;
        p_d     = p_inc;
        state_d = S_PSTART;
      end
      S_EREAD: begin
        rd_addr = k_q[IDX_W-1:0];
        state_d = S_EOUT;
      end
      S_EOUT: begin
        rd_addr = k_q[IDX_W-1:0];
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = rdata_q;
          out_last_d  = (k_inc == num_q);
          k_d         = k_inc;
          if (k_inc == num_q) begin
            fill_d  = '0;
            state_d = S_LOAD;
          end else begin
            state_d = S_EREAD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      fill_q      <= '0;
      num_q       <= '0;
      p_q         <= '0;
      q_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      num_q       <= num_d;
      p_q         <= p_d;
      q_q         <= q_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/exchange_sort_engine_top.sv
// Top level of the exchange sort engine.
//
// The engine collects a set of signed 32-bit values, one per input transaction, and a
// transaction with last_item_i set closes the set. Up to MAX_ELEMENTS values are kept;
// values that arrive once the store is full are dropped, but their last mark still closes
// the set. The closed set is sorted in ascending order by exchange sort and sent out
// smallest first, with last_result_o set on the final value. A four-entry queue sits
// between the input side and the sorting sequencer, so input transactions keep being
// accepted while the sequencer is busy until that queue fills. Loading pops one queued
// transaction whenever the queue holds one. Sorting is set by the single read and write
// port of the store: each compare-swap step reads one entry and may write one entry per
// cycle. Each emitted result again takes one store read.
module exchange_sort_engine_top #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [esort_pkg::DATA_W-1:0]   value_i,
  input  logic                                  last_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [esort_pkg::DATA_W-1:0]   sorted_value_o,
  output logic                                  last_result_o
);

  logic              q_valid;
  logic              q_pop;
  esort_pkg::entry_t q_entry;

  // The front end tags each transaction as kept or dropped and queues it.
  esort_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .last_item_i(last_item_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  // The back end owns the store, runs the sort and drives the output register.
  esort_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .last_result_o (last_result_o)
  );

endmodule
